FILE: hw/rtl/instruction_word_decoder_unit_assert.svh
// Assertion macros used by the decoder checker.
`ifndef INSTRUCTION_WORD_DECODER_UNIT_ASSERT_SVH
`define INSTRUCTION_WORD_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define IWD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define IWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

FILE: hw/rtl/iwd_pkg.sv
package iwd_pkg;

  // Format codes on the result
  localparam logic [3:0] FMT_4OP     = 4'd0;
  localparam logic [3:0] FMT_3OP     = 4'd1;
  localparam logic [3:0] FMT_2OP     = 4'd2;
  localparam logic [3:0] FMT_1OP     = 4'd3;
  localparam logic [3:0] FMT_2OPI    = 4'd4;
  localparam logic [3:0] FMT_1OPI    = 4'd5;
  localparam logic [3:0] FMT_BR1OPI  = 4'd6;
  localparam logic [3:0] FMT_0OPI    = 4'd7;
  localparam logic [3:0] FMT_HALCODE = 4'd8;
  localparam logic [3:0] FMT_0OP     = 4'd9;
  localparam logic [3:0] FMT_UNSUP   = 4'd10;

  // First-byte format selectors
  localparam logic [7:0] OPC_4OP     = 8'h01;
  localparam logic [7:0] OPC_3OP     = 8'h05;
  localparam logic [7:0] OPC_2OP     = 8'h09;
  localparam logic [7:0] OPC_1OP     = 8'h0D;
  localparam logic [7:0] OPC_2OPI_LO = 8'h0E;
  localparam logic [7:0] OPC_2OPI_HI = 8'h2B;
  localparam logic [7:0] OPC_1OPI    = 8'h2C;
  localparam logic [7:0] OPC_BR1OPI  = 8'h2D;
  localparam logic [7:0] OPC_0OPI    = 8'h3C;
  localparam logic [7:0] OPC_HALCODE = 8'h42;
  localparam logic [7:0] OPC_NOP     = 8'h00;
  localparam logic [7:0] OPC_HALT    = 8'hFF;

  // Dense indexes of the 0OP group
  localparam logic [5:0] OP0_NOP        = 6'd0;
  localparam logic [5:0] OP0_BAD_NOP    = 6'd1;
  localparam logic [5:0] OP0_BAD_HALT   = 6'd2;
  localparam logic [5:0] OP0_HALT       = 6'd3;

  // Decoded instruction
  typedef struct packed {
    logic [3:0]  format;
    logic [5:0]  operation;
    logic        legal;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [3:0]  reg_c;
    logic [3:0]  reg_d;
    logic [15:0] immediate;
  } result_t;

endpackage

FILE: hw/rtl/iwd_decode.sv
module iwd_decode (
  input  logic [31:0]          word_i,
  output iwd_pkg::result_t     result_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic [11:0] c12;
  logic [15:0] c16;
  logic [19:0] c20;
  logic [23:0] c24;

  assign b0  = word_i[31:24];
  assign b1  = word_i[23:16];
  assign b2  = word_i[15:8];
  assign b3  = word_i[7:0];
  assign c12 = word_i[23:12];
  assign c16 = word_i[23:8];
  assign c20 = word_i[23:4];
  assign c24 = word_i[23:0];

  // Select format, cut fields and look up the operation
  always_comb begin
    result_o           = '0;
    result_o.format    = iwd_pkg::FMT_UNSUP;
    if (b0 == iwd_pkg::OPC_4OP) begin
      result_o.format = iwd_pkg::FMT_4OP;
      result_o.reg_a  = b2[7:4];
      result_o.reg_b  = b2[3:0];
      result_o.reg_c  = b3[7:4];
      result_o.reg_d  = b3[3:0];
      if (b1 < 8'd20) begin
        result_o.legal     = 1'b1;
        result_o.operation = b1[5:0];
      end
    end else if (b0 == iwd_pkg::OPC_3OP) begin
      result_o.format = iwd_pkg::FMT_3OP;
      result_o.reg_a  = b2[3:0];
      result_o.reg_b  = b3[7:4];
      result_o.reg_c  = b3[3:0];
      if (c12[11:6] == 6'd0) begin
        case (c12[5:4])
          2'd0: begin
            if (c12[3:0] < 4'd14) begin
              result_o.legal     = 1'b1;
              result_o.operation = 6'(c12[3:0]);
            end
          end
          2'd1: begin
            if (c12[3:0] < 4'd12) begin
              result_o.legal     = 1'b1;
              result_o.operation = 6'(c12[3:0]) + 6'd14;
            end
          end
          2'd2: begin
            if (c12[3:0] < 4'd10) begin
              result_o.legal     = 1'b1;
              result_o.operation = 6'(c12[3:0]) + 6'd26;
            end
          end
          default: begin
            if (c12[3:0] < 4'd8) begin
              result_o.legal     = 1'b1;
              result_o.operation = 6'(c12[3:0]) + 6'd36;
            end
          end
        endcase
      end
    end else if (b0 == iwd_pkg::OPC_2OP) begin
      result_o.format = iwd_pkg::FMT_2OP;
      result_o.reg_a  = b3[7:4];
      result_o.reg_b  = b3[3:0];
      if (c16 < 16'd6) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c16[2:0]);
      end else if (c16[15:1] == 15'h0080) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c16[0]) + 6'd6;
      end
    end else if (b0 == iwd_pkg::OPC_1OP) begin
      result_o.format = iwd_pkg::FMT_1OP;
      result_o.reg_a  = b3[3:0];
      if (c20[19:2] == 18'd0) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c20[1:0]);
      end else if (c20[19:1] == 19'h00800) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c20[0]) + 6'd4;
      end else if (c20[19:1] == 19'h01000) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c20[0]) + 6'd6;
      end
    end else if (b0 >= iwd_pkg::OPC_2OPI_LO && b0 <= iwd_pkg::OPC_2OPI_HI) begin
      result_o.format    = iwd_pkg::FMT_2OPI;
      result_o.reg_a     = b1[7:4];
      result_o.reg_b     = b1[3:0];
      result_o.immediate = word_i[15:0];
      if (b0 <= 8'h19) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(b0 - iwd_pkg::OPC_2OPI_LO);
      end else if (b0 == 8'h1F) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'd12;
      end else if (b0 >= 8'h20 && b0 <= 8'h26) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(b0[2:0]) + 6'd13;
      end
    end else if (b0 == iwd_pkg::OPC_1OPI) begin
      result_o.format    = iwd_pkg::FMT_1OPI;
      result_o.reg_a     = b1[3:0];
      result_o.immediate = word_i[15:0];
      if (b1[7:4] < 4'd11) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(b1[7:4]);
      end
    end else if (b0 == iwd_pkg::OPC_BR1OPI) begin
      result_o.format    = iwd_pkg::FMT_BR1OPI;
      result_o.reg_a     = b1[3:0];
      result_o.immediate = word_i[15:0];
      if (b1[7:4] < 4'd9) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(b1[7:4]);
      end
    end else if (b0 == iwd_pkg::OPC_0OPI) begin
      result_o.format    = iwd_pkg::FMT_0OPI;
      result_o.immediate = word_i[15:0];
      result_o.legal     = (b1 == 8'h00);
    end else if (b0 == iwd_pkg::OPC_HALCODE) begin
      result_o.format = iwd_pkg::FMT_HALCODE;
      if (c24[23:2] == 22'h040000) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'(c24[1:0]);
      end else if (c24 == 24'h100100) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'd4;
      end else if (c24 == 24'h100200) begin
        result_o.legal     = 1'b1;
        result_o.operation = 6'd5;
      end
    end else if (b0 == iwd_pkg::OPC_NOP) begin
      result_o.format    = iwd_pkg::FMT_0OP;
      result_o.legal     = 1'b1;
      result_o.operation = (c24 == 24'd0) ? iwd_pkg::OP0_NOP : iwd_pkg::OP0_BAD_NOP;
    end else if (b0 == iwd_pkg::OPC_HALT) begin
      result_o.format    = iwd_pkg::FMT_0OP;
      result_o.legal     = 1'b1;
      result_o.operation = (c24 == 24'hFFFFFF) ? iwd_pkg::OP0_HALT
                                               : iwd_pkg::OP0_BAD_HALT;
    end
  end

endmodule

FILE: hw/rtl/instruction_word_decoder_unit.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------
// in       | input     | in_valid_i/in_stall_o  | instruction_word_i
// out      | output    | out_valid_o/out_stall_i| format_o, operation_o, legal_o,
//          |           |                        | reg_a_o..reg_d_o, immediate_o
//
// One instruction word per cycle while the output is not stalled; each word
// passes the input register, then the result register, decoded in between.
// Reset clears both stage valid bits; payload registers are not reset.
// A stall on the output holds the result; the input stage still takes a
// transaction while it is empty, so the input stalls only when both stages hold.
module instruction_word_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instruction_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         format_o,
  output logic [5:0]         operation_o,
  output logic               legal_o,
  output logic [3:0]         reg_a_o,
  output logic [3:0]         reg_b_o,
  output logic [3:0]         reg_c_o,
  output logic [3:0]         reg_d_o,
  output logic signed [15:0] immediate_o
);

  logic             in_valid_q, in_valid_d;
  logic [31:0]      word_q;
  logic             res_valid_q, res_valid_d;
  iwd_pkg::result_t res_q;
  iwd_pkg::result_t dec_result;
  logic             in_adv, res_adv;

  // Advance a stage when it is empty or the stage after it moves
  assign res_adv     = !res_valid_q || !out_stall_i;
  assign in_adv      = !in_valid_q || res_adv;
  assign in_stall_o  = !in_adv;
  assign in_valid_d  = in_adv ? in_valid_i : in_valid_q;
  assign res_valid_d = res_adv ? in_valid_q : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      word_q <= instruction_word_i;
    end
  end

  iwd_decode u_decode (
    .word_i   (word_q),
    .result_o (dec_result)
  );

  // Capture the decoded result
  always_ff @(posedge clk_i) begin
    if (res_adv && in_valid_q) begin
      res_q <= dec_result;
    end
  end

  assign out_valid_o = res_valid_q;
  assign format_o    = res_q.format;
  assign operation_o = res_q.operation;
  assign legal_o     = res_q.legal;
  assign reg_a_o     = res_q.reg_a;
  assign reg_b_o     = res_q.reg_b;
  assign reg_c_o     = res_q.reg_c;
  assign reg_d_o     = res_q.reg_d;
  assign immediate_o = $signed(res_q.immediate);

endmodule

FILE: hw/rtl/iwd_checker.sv
`include "instruction_word_decoder_unit_assert.svh"

module iwd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [3:0]         format_o,
  input logic [5:0]         operation_o,
  input logic               legal_o,
  input logic [3:0]         reg_a_o,
  input logic [3:0]         reg_b_o,
  input logic [3:0]         reg_c_o,
  input logic [3:0]         reg_d_o,
  input logic signed [15:0] immediate_o
);

  // Hold a stalled result
  `IWD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(format_o) && $stable(operation_o) && $stable(immediate_o))

  // Drop the operation index on an illegal word
  `IWD_ASSERT_NOW(a_illegal_op_zero, out_valid_o && !legal_o, operation_o == 6'd0)

  // Clear every field of an unsupported word
  `IWD_ASSERT_NOW(a_unsup_clear, out_valid_o && format_o == iwd_pkg::FMT_UNSUP, !legal_o && reg_a_o == 4'd0 && reg_b_o == 4'd0 && reg_c_o == 4'd0 && reg_d_o == 4'd0 && immediate_o == 16'sd0)

  // Keep the immediate zero outside the immediate formats
  `IWD_ASSERT_NOW(a_imm_formats, out_valid_o && immediate_o != 16'sd0, format_o == iwd_pkg::FMT_2OPI || format_o == iwd_pkg::FMT_1OPI || format_o == iwd_pkg::FMT_BR1OPI || format_o == iwd_pkg::FMT_0OPI)

  // Stall the input only while a result is held back
  `IWD_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind instruction_word_decoder_unit iwd_checker u_iwd_checker (.*);
